>>> rtl/blr_pkg.sv
// ============================================================================
// blr_pkg - shared types and constants of the line rasterizer
// Register indexes, reset values, field widths and the frame config struct.
// ============================================================================
`default_nettype none

package blr_pkg;

    // Fixed field widths
    localparam int FRAME_BITS = 13;
    localparam int ADDR_BITS  = 24;
    localparam int COLOR_BITS = 32;

    // Configuration register indexes
    localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

    // Configuration reset values
    localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;

    // Action codes carried on the input tuser
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_NEXT  = 1'b1;

    // Frame geometry as seen by the clip/address stage
    typedef struct packed {
        logic [FRAME_BITS-1:0] height;
        logic [FRAME_BITS-1:0] width;
    } t_cfg;

endpackage

`default_nettype wire

>>> rtl/blr_stepper.sv
// ============================================================================
// blr_stepper - line setup and Bresenham stepping
// Holds the line state. A start transfer sets up the major/minor axes and the
// doubled error terms; each next on an active line registers a pixel and steps.
// ============================================================================
`default_nettype none

module blr_stepper #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic                              i_action,
    input  wire logic signed [COORD_BITS-1:0]      i_start_x,
    input  wire logic signed [COORD_BITS-1:0]      i_start_y,
    input  wire logic signed [COORD_BITS-1:0]      i_end_x,
    input  wire logic signed [COORD_BITS-1:0]      i_end_y,
    input  wire logic [blr_pkg::COLOR_BITS-1:0]    i_color,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [COORD_BITS-1:0]           o_px,
    output logic signed [COORD_BITS-1:0]           o_py,
    output logic                                   o_last,
    output logic [blr_pkg::COLOR_BITS-1:0]         o_color
);

    localparam int N  = COORD_BITS;
    localparam int EW = COORD_BITS + 4;

    // Line state
    logic                           r_line_active, n_line_active;
    logic signed [N-1:0]            r_major_pos;
    logic signed [N-1:0]            r_major_end;
    logic signed [N-1:0]            r_minor_pos;
    logic signed [EW-1:0]           r_error_acc;
    logic [N+1:0]                   r_error_step;
    logic [N+1:0]                   r_error_wrap;
    logic                           r_minor_neg;
    logic                           r_axes_swapped;
    logic [blr_pkg::COLOR_BITS-1:0] r_line_color;

    // Pixel register
    logic                           r_valid, n_valid;
    logic signed [N-1:0]            r_px;
    logic signed [N-1:0]            r_py;
    logic                           r_last;
    logic [blr_pkg::COLOR_BITS-1:0] r_color;

    logic                           accept;
    logic                           do_start;
    logic                           do_step;

    // Setup terms
    logic signed [N:0]              dx_raw, dy_raw;
    logic [N:0]                     adx, ady;
    logic                           steep;
    logic signed [N-1:0]            mj_a, mj_b, mn_a, mn_b;
    logic                           order_swap;
    logic signed [N-1:0]            maj0, maj1, min0, min1;
    logic signed [N:0]              dmaj, dmin;
    logic [N:0]                     admin;

    // Step terms
    logic signed [EW-1:0]           err_sum;
    logic signed [EW-1:0]           err_half;
    logic signed [EW-1:0]           err_wrap_s;
    logic                           minor_move;
    logic                           at_end;

    assign o_ready  = !r_valid || i_ready;
    assign accept   = i_valid && o_ready;
    assign do_start = accept && (i_action == blr_pkg::ACT_START);
    assign do_step  = accept && (i_action == blr_pkg::ACT_NEXT) && r_line_active;

    // Line setup: steep test, axis swap, endpoint ordering
    always_comb begin
        dx_raw     = (N+1)'(i_end_x) - (N+1)'(i_start_x);
        dy_raw     = (N+1)'(i_end_y) - (N+1)'(i_start_y);
        adx        = dx_raw[N] ? $unsigned(-dx_raw) : $unsigned(dx_raw);
        ady        = dy_raw[N] ? $unsigned(-dy_raw) : $unsigned(dy_raw);
        steep      = ady > adx;
        mj_a       = steep ? i_start_y : i_start_x;
        mn_a       = steep ? i_start_x : i_start_y;
        mj_b       = steep ? i_end_y   : i_end_x;
        mn_b       = steep ? i_end_x   : i_end_y;
        order_swap = mj_a > mj_b;
        maj0       = order_swap ? mj_b : mj_a;
        maj1       = order_swap ? mj_a : mj_b;
        min0       = order_swap ? mn_b : mn_a;
        min1       = order_swap ? mn_a : mn_b;
        dmaj       = (N+1)'(maj1) - (N+1)'(maj0);
        dmin       = (N+1)'(min1) - (N+1)'(min0);
        admin      = dmin[N] ? $unsigned(-dmin) : $unsigned(dmin);
    end

    // Per-pixel error update
    always_comb begin
        err_sum    = r_error_acc + $signed({2'b00, r_error_step});
        err_half   = $signed({3'b000, r_error_wrap[N+1:1]});
        err_wrap_s = $signed({2'b00, r_error_wrap});
        minor_move = err_sum > err_half;
        at_end     = r_major_pos == r_major_end;
    end

    // Next control state
    always_comb begin
        n_line_active = r_line_active;
        if (do_start) begin
            n_line_active = 1'b1;
        end else if (do_step && at_end) begin
            n_line_active = 1'b0;
        end
        n_valid = o_ready ? do_step : r_valid;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_active <= 1'b0;
            r_valid       <= 1'b0;
        end else begin
            r_line_active <= n_line_active;
            r_valid       <= n_valid;
        end
    end

    // Line state and pixel payload
    always_ff @(posedge i_clk) begin
        if (do_start) begin
            r_axes_swapped <= steep;
            r_major_pos    <= maj0;
            r_major_end    <= maj1;
            r_minor_pos    <= min0;
            r_error_acc    <= '0;
            r_error_step   <= {admin, 1'b0};
            r_error_wrap   <= {$unsigned(dmaj), 1'b0};
            r_minor_neg    <= dmin[N];
            r_line_color   <= i_color;
        end else if (do_step && !at_end) begin
            r_major_pos <= r_major_pos + N'(1);
            if (minor_move) begin
                r_minor_pos <= r_minor_neg ? r_minor_pos - N'(1) : r_minor_pos + N'(1);
                r_error_acc <= err_sum - err_wrap_s;
            end else begin
                r_error_acc <= err_sum;
            end
        end
        if (do_step) begin
            r_px    <= r_axes_swapped ? r_minor_pos : r_major_pos;
            r_py    <= r_axes_swapped ? r_major_pos : r_minor_pos;
            r_last  <= at_end;
            r_color <= r_line_color;
        end
    end

    assign o_valid = r_valid;
    assign o_px    = r_px;
    assign o_py    = r_py;
    assign o_last  = r_last;
    assign o_color = r_color;

endmodule

`default_nettype wire

>>> rtl/blr_pixel_out.sv
// ============================================================================
// blr_pixel_out - frame clipping, address and output register
// Tests the pixel against the frame size, forms y*width+x and holds the result
// until the downstream side takes it.
// ============================================================================
`default_nettype none

module blr_pixel_out #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire blr_pkg::t_cfg                     i_cfg,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [COORD_BITS-1:0]      i_px,
    input  wire logic signed [COORD_BITS-1:0]      i_py,
    input  wire logic                              i_last,
    input  wire logic [blr_pkg::COLOR_BITS-1:0]    i_color,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [COORD_BITS-1:0]           o_px,
    output logic signed [COORD_BITS-1:0]           o_py,
    output logic                                   o_inside,
    output logic [blr_pkg::ADDR_BITS-1:0]          o_addr,
    output logic [blr_pkg::COLOR_BITS-1:0]         o_color,
    output logic                                   o_last
);

    localparam int N  = COORD_BITS;
    localparam int FB = blr_pkg::FRAME_BITS;
    localparam int UW = COORD_BITS + blr_pkg::FRAME_BITS;

    logic                           r_valid;
    logic signed [N-1:0]            r_px;
    logic signed [N-1:0]            r_py;
    logic                           r_inside;
    logic [blr_pkg::ADDR_BITS-1:0]  r_addr;
    logic [blr_pkg::COLOR_BITS-1:0] r_color;
    logic                           r_last;

    logic [UW-1:0]                  px_u, py_u;
    logic                           in_frame;
    logic [2*FB-1:0]                prod;
    logic [blr_pkg::ADDR_BITS-1:0]  addr;

    assign o_ready = !r_valid || i_ready;

    // Clip against the frame and form the linear address
    always_comb begin
        px_u     = UW'($unsigned(i_px));
        py_u     = UW'($unsigned(i_py));
        in_frame = !i_px[N-1] && !i_py[N-1] &&
                   (px_u < UW'(i_cfg.width)) && (py_u < UW'(i_cfg.height));
        prod     = {{FB{1'b0}}, py_u[FB-1:0]} * {{FB{1'b0}}, i_cfg.width};
        addr     = in_frame ? prod[blr_pkg::ADDR_BITS-1:0] +
                              blr_pkg::ADDR_BITS'(px_u[FB-1:0]) : '0;
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_px     <= i_px;
            r_py     <= i_py;
            r_inside <= in_frame;
            r_addr   <= addr;
            r_color  <= i_color;
            r_last   <= i_last;
        end
    end

    assign o_valid  = r_valid;
    assign o_px     = r_px;
    assign o_py     = r_py;
    assign o_inside = r_inside;
    assign o_addr   = r_addr;
    assign o_color  = r_color;
    assign o_last   = r_last;

endmodule

`default_nettype wire

>>> rtl/bresenham_line_rasterizer.sv
// ============================================================================
// bresenham_line_rasterizer - streaming integer line rasterizer
// Usage:
//   Slave channel: tuser = action (start / next), tdata = endpoints and color.
//   A start transfer loads a new line (replacing any line in progress) and
//   gives no result. Each next transfer while a line is active gives one pixel
//   on the master channel; a next with no line active gives nothing.
//   Master channel: tdata = x, y, framebuffer address, color; tuser = inside
//   flag (address is zero when outside); tlast marks the far endpoint.
//   Config port: write frame width (index 0) or height (index 1) while idle.
// Pipeline: two register stages, the pixel register of the stepping stage and
// then the output register.
// Throughput: 1 transfer per cycle while s_axis_tready is high; the error
// add/compare feeds the line state register, and the address multiply has its own stage.
// Reset: no line active, pipeline empty, frame size 640 x 480.
// Stall: when the receiver holds tready low the output register holds; the
// stepping stage keeps taking transfers until it holds a pixel too, then
// tready on the slave side drops.
// ============================================================================
`default_nettype none

module bresenham_line_rasterizer #(
    parameter  int COORD_BITS = 16,
    localparam int IN_W  = ((4 * COORD_BITS + blr_pkg::COLOR_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * COORD_BITS + blr_pkg::ADDR_BITS
                             + blr_pkg::COLOR_BITS + 7) / 8) * 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // slave side
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: start_x, start_y, end_x, end_y, draw_color (from bit 0 up)
    input  wire logic [IN_W-1:0]                   s_axis_tdata,
    // tuser: action
    input  wire logic                              s_axis_tuser,
    // master side
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // tdata: pixel_x, pixel_y, pixel_address, pixel_color (from bit 0 up)
    output logic [OUT_W-1:0]                       m_axis_tdata,
    // tuser: inside_frame
    output logic                                   m_axis_tuser,
    output logic                                   m_axis_tlast,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [0:0]                        i_cfg_index,
    input  wire logic [blr_pkg::FRAME_BITS-1:0]    i_cfg_data
);

    localparam int N = COORD_BITS;

    blr_pkg::t_cfg                  r_cfg;

    logic                           st_valid, st_ready;
    logic signed [N-1:0]            st_px, st_py;
    logic                           st_last;
    logic [blr_pkg::COLOR_BITS-1:0] st_color;

    logic signed [N-1:0]            out_px, out_py;
    logic [blr_pkg::ADDR_BITS-1:0]  out_addr;
    logic [blr_pkg::COLOR_BITS-1:0] out_color;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= blr_pkg::FRAME_WIDTH_RST;
            r_cfg.height <= blr_pkg::FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                blr_pkg::REG_FRAME_WIDTH:  r_cfg.width  <= i_cfg_data;
                blr_pkg::REG_FRAME_HEIGHT: r_cfg.height <= i_cfg_data;
            endcase
        end
    end

    // Line state and stepping
    blr_stepper #(
        .COORD_BITS (COORD_BITS)
    ) u_stepper (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_action  (s_axis_tuser),
        .i_start_x ($signed(s_axis_tdata[N-1:0])),
        .i_start_y ($signed(s_axis_tdata[2*N-1:N])),
        .i_end_x   ($signed(s_axis_tdata[3*N-1:2*N])),
        .i_end_y   ($signed(s_axis_tdata[4*N-1:3*N])),
        .i_color   (s_axis_tdata[4*N+blr_pkg::COLOR_BITS-1:4*N]),
        .o_valid   (st_valid),
        .i_ready   (st_ready),
        .o_px      (st_px),
        .o_py      (st_py),
        .o_last    (st_last),
        .o_color   (st_color)
    );

    // Clip, address and output register
    blr_pixel_out #(
        .COORD_BITS (COORD_BITS)
    ) u_pixel_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (st_valid),
        .o_ready  (st_ready),
        .i_px     (st_px),
        .i_py     (st_py),
        .i_last   (st_last),
        .i_color  (st_color),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_px     (out_px),
        .o_py     (out_py),
        .o_inside (m_axis_tuser),
        .o_addr   (out_addr),
        .o_color  (out_color),
        .o_last   (m_axis_tlast)
    );

    // Pack result fields, zero padded to whole bytes
    assign m_axis_tdata = OUT_W'({out_color, out_addr, out_py, out_px});

endmodule

`default_nettype wire

>>> rtl/blr_checker.sv
// ============================================================================
// blr_checker - port-level checks of the line rasterizer
// Watches the master channel and reset; bound to the top level below.
// ============================================================================
`default_nettype none

module blr_checker #(
    parameter  int COORD_BITS = 16,
    localparam int OUT_W = ((2 * COORD_BITS + blr_pkg::ADDR_BITS
                             + blr_pkg::COLOR_BITS + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             m_axis_tvalid,
    input  wire logic             m_axis_tready,
    input  wire logic [OUT_W-1:0] m_axis_tdata,
    input  wire logic             m_axis_tuser,
    input  wire logic             m_axis_tlast
);

    localparam int N = COORD_BITS;

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Clipped pixels carry a zero address
    a_clip_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tdata[2*N+blr_pkg::ADDR_BITS-1:2*N] == '0)
        else $error("outside pixel with nonzero address");

    // Inside pixels have nonnegative coordinates
    a_inside_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            !m_axis_tdata[N-1] && !m_axis_tdata[2*N-1])
        else $error("inside pixel with negative coordinate");

endmodule

bind bresenham_line_rasterizer blr_checker #(
    .COORD_BITS (COORD_BITS)
) u_blr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb - self-checking bench for the line rasterizer
// Start and next commands go in on the slave stream; every accepted command
// is run through a cycle-free model of the rasterizer and the pixels it
// predicts are queued. Each pixel on the master stream is compared against
// the oldest queued pixel. Phases vary the frame size (zero, one, maximum,
// wrap-around) and the idle/stall mix. One phase holds the output for a long
// stretch, and another drains every pixel before the sender continues.
// ============================================================================

module tb;

    localparam int COORD       = 16;
    localparam int IN_W        = 96;
    localparam int OUT_W       = 88;
    localparam int DRAIN_GAP   = 8;        // pipeline latency plus margin
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 200000;

    // One command for the slave stream
    typedef struct {
        bit                                 pause;  // hold the sender until all pixels are back
        logic                               act;
        logic signed [COORD-1:0]            sx, sy, ex, ey;
        logic [blr_pkg::COLOR_BITS-1:0]     color;
    } t_line_cmd;

    typedef struct packed {
        logic signed [COORD-1:0]            x;
        logic signed [COORD-1:0]            y;
        logic                               in_frame;
        logic [blr_pkg::ADDR_BITS-1:0]      addr;
        logic [blr_pkg::COLOR_BITS-1:0]     color;
        logic                               last;
    } t_pixel;

    // Clock and DUT-facing signals
    logic                           i_clk     = 1'b0;
    logic                           i_rst_n   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic [IN_W-1:0]                s_tdata   = '0;
    logic                           s_tuser   = 1'b0;
    logic                           m_tready  = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [0:0]                     cfg_index = blr_pkg::REG_FRAME_WIDTH;
    logic [blr_pkg::FRAME_BITS-1:0] cfg_data  = '0;
    wire                            s_tready;
    wire                            m_tvalid;
    wire [OUT_W-1:0]                m_tdata;
    wire                            m_tuser;
    wire                            m_tlast;

    // Stimulus and scoreboard
    t_line_cmd line_cmds[$];
    t_pixel    expected_pixels[$];
    t_line_cmd drv_cmd;
    t_pixel    seen_pix;
    t_pixel    want_pix;
    int        items_queued   = 0;
    int        pixel_errors   = 0;
    int        cycle_count    = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    bit        in_fire        = 1'b0;
    bit        long_hold_req  = 1'b0;
    bit        long_hold_done = 1'b0;
    int        hold_count     = 0;

    // Rasterizer model state
    logic [blr_pkg::FRAME_BITS-1:0] frame_w = blr_pkg::FRAME_WIDTH_RST;
    logic [blr_pkg::FRAME_BITS-1:0] frame_h = blr_pkg::FRAME_HEIGHT_RST;
    bit                             ln_active = 1'b0;
    logic signed [COORD-1:0]        maj_pos = '0;
    logic signed [COORD-1:0]        maj_end = '0;
    logic signed [COORD-1:0]        min_pos = '0;
    int                             err_acc = 0;
    int                             err_step = 0;
    int                             err_wrap = 0;
    bit                             min_neg = 1'b0;
    bit                             swapped = 1'b0;
    logic [blr_pkg::COLOR_BITS-1:0] ln_color = '0;

    bresenham_line_rasterizer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int iabs(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // Model of one accepted command; a pixel it emits goes to the expected queue
    task automatic raster_step(input logic act, input logic signed [COORD-1:0] sx, sy, ex, ey,
                               input logic [blr_pkg::COLOR_BITS-1:0] color);
        int     ax, ay, bx, by, t;
        int     xi, yi;
        bit     steep;
        t_pixel pix;
        if (act == blr_pkg::ACT_START) begin
            ax = sx; ay = sy; bx = ex; by = ey;
            steep = iabs(by - ay) > iabs(bx - ax);
            if (steep) begin
                t = ax; ax = ay; ay = t;
                t = bx; bx = by; by = t;
            end
            // walk the major axis upward
            if (ax > bx) begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
            end
            swapped   = steep;
            maj_pos   = 16'(ax);
            maj_end   = 16'(bx);
            min_pos   = 16'(ay);
            err_acc   = 0;
            err_step  = 2 * iabs(by - ay);
            err_wrap  = 2 * (bx - ax);
            min_neg   = (by - ay) < 0;
            ln_color  = color;
            ln_active = 1'b1;
        end else if (ln_active) begin
            pix.x        = swapped ? min_pos : maj_pos;
            pix.y        = swapped ? maj_pos : min_pos;
            xi           = pix.x;
            yi           = pix.y;
            pix.in_frame = xi >= 0 && yi >= 0 && xi < int'(frame_w) && yi < int'(frame_h);
            pix.addr     = pix.in_frame ? 24'(yi * int'(frame_w) + xi) : '0;
            pix.color    = ln_color;
            pix.last     = (maj_pos == maj_end);
            expected_pixels.push_back(pix);
            if (pix.last) begin
                ln_active = 1'b0;
            end else begin
                err_acc = err_acc + err_step;
                if (err_acc > err_wrap / 2) begin
                    min_pos = min_neg ? min_pos - 16'sd1 : min_pos + 16'sd1;
                    err_acc = err_acc - err_wrap;
                end
                maj_pos = maj_pos + 16'sd1;
            end
        end
    endtask

    task automatic post_start(input int sx, sy, ex, ey,
                              input logic [blr_pkg::COLOR_BITS-1:0] color);
        t_line_cmd c;
        c.pause = 1'b0;
        c.act   = blr_pkg::ACT_START;
        c.sx    = 16'(sx);
        c.sy    = 16'(sy);
        c.ex    = 16'(ex);
        c.ey    = 16'(ey);
        c.color = color;
        line_cmds.push_back(c);
        items_queued++;
    endtask

    // Next commands carry random payload, which the block must ignore
    task automatic post_next(input int n);
        t_line_cmd c;
        for (int k = 0; k < n; k++) begin
            c.pause = 1'b0;
            c.act   = blr_pkg::ACT_NEXT;
            c.sx    = 16'($urandom);
            c.sy    = 16'($urandom);
            c.ex    = 16'($urandom);
            c.ey    = 16'($urandom);
            c.color = $urandom;
            line_cmds.push_back(c);
            items_queued++;
        end
    endtask

    // One random line around the frame, or a full-range one, and its nexts
    task automatic queue_line(input int w, input int h);
        int x0, y0, dx, dy, len;
        if ($urandom_range(0, 7) == 0) begin
            // full-range endpoints: long lines, only the first pixels are taken
            post_start($urandom, $urandom, $urandom, $urandom, $urandom);
            post_next($urandom_range(1, 12));
        end else begin
            x0  = $urandom_range(0, w + 8) - 4;
            y0  = $urandom_range(0, h + 8) - 4;
            dx  = $urandom_range(0, 24) - 12;
            dy  = $urandom_range(0, 24) - 12;
            len = (iabs(dx) > iabs(dy)) ? iabs(dx) : iabs(dy);
            post_start(x0, y0, x0 + dx, y0 + dy, $urandom);
            case ($urandom_range(0, 7))
                0: post_next($urandom_range(0, len));            // replaced mid-line
                1: post_next(len + 1 + $urandom_range(1, 3));    // nexts past the end
                default: post_next(len + 1);
            endcase
        end
    endtask

    // Block is idle once nothing is queued, offered or outstanding
    task automatic wait_idle();
        while (line_cmds.size() != 0 || s_tvalid || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic set_frame(input int w, input int h);
        wait_idle();
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= blr_pkg::REG_FRAME_WIDTH;
        cfg_data  <= 13'(w);
        @(negedge i_clk);
        cfg_index <= blr_pkg::REG_FRAME_HEIGHT;
        cfg_data  <= 13'(h);
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        frame_w = 13'(w);
        frame_h = 13'(h);
    endtask

    task automatic run_phase(input int w, h, idle_pct, stall_pct, n, input bit drain_mid);
        int        goal;
        t_line_cmd pause_cmd;
        set_frame(w, h);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        goal = items_queued + n;
        while (items_queued < goal) begin
            if (drain_mid && items_queued >= goal - n / 2) begin
                pause_cmd.pause = 1'b1;
                line_cmds.push_back(pause_cmd);
                drain_mid = 1'b0;
            end
            queue_line(w, h);
            // stray nexts: extra pixels of a cut line, or nothing at all
            if ($urandom_range(0, 9) == 0)
                post_next($urandom_range(1, 3));
        end
    endtask

    // Slave-side driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (line_cmds.size() != 0 && line_cmds[0].pause) begin
                if (expected_pixels.size() == 0)
                    void'(line_cmds.pop_front());
                s_tvalid <= 1'b0;
            end else if (line_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                drv_cmd  = line_cmds.pop_front();
                s_tdata  <= {drv_cmd.color, drv_cmd.ey, drv_cmd.ex, drv_cmd.sy, drv_cmd.sx};
                s_tuser  <= drv_cmd.act;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Master-side ready: random stalls, plus one long hold on request
    always @(negedge i_clk) begin
        if (long_hold_req && !long_hold_done) begin
            m_tready <= 1'b0;
            hold_count = hold_count + 1;
            if (hold_count >= LONG_HOLD)
                long_hold_done = 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on input transfers, check output transfers
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        in_fire = i_rst_n && s_tvalid && s_tready;
        if (in_fire)
            raster_step(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[47:32],
                        s_tdata[63:48], s_tdata[95:64]);
        if (i_rst_n && m_tvalid && m_tready) begin
            seen_pix.x        = m_tdata[15:0];
            seen_pix.y        = m_tdata[31:16];
            seen_pix.addr     = m_tdata[55:32];
            seen_pix.color    = m_tdata[87:56];
            seen_pix.in_frame = m_tuser;
            seen_pix.last     = m_tlast;
            if (expected_pixels.size() == 0) begin
                pixel_errors++;
                if (pixel_errors <= 10)
                    $display("unexpected pixel x=%0d y=%0d", seen_pix.x, seen_pix.y);
            end else begin
                want_pix = expected_pixels.pop_front();
                if (seen_pix !== want_pix) begin
                    pixel_errors++;
                    if (pixel_errors <= 10)
                        $display("pixel mismatch exp x=%0d y=%0d in=%b adr=%h col=%h last=%b",
                                 want_pix.x, want_pix.y, want_pix.in_frame, want_pix.addr,
                                 want_pix.color, want_pix.last,
                                 " | got x=%0d y=%0d in=%b adr=%h col=%h last=%b",
                                 seen_pix.x, seen_pix.y, seen_pix.in_frame, seen_pix.addr,
                                 seen_pix.color, seen_pix.last);
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge i_clk);
        $display("FAIL bresenham_line_rasterizer");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines at the reset frame size
        post_next(1);                                        // no line active yet
        post_start(5, 5, 5, 5, 32'h0000_0000);               // single-point line
        post_next(2);
        post_start(0, 0, 3, 0, 32'hFFFF_FFFF);               // flat line
        post_next(4);
        post_start(1, 0, 0, 3, 32'h1234_5678);               // steep, reversed minor
        post_next(4);
        post_start(639, 479, 641, 480, 32'h0BAD_F00D);       // crosses the frame corner
        post_next(3);
        post_start(-32768, -32768, 32767, 32767, 32'hA5A5_A5A5);
        post_next(2);
        post_start(32767, -32768, -32768, 32767, 32'h5A5A_5A5A); // replaces line in progress
        post_next(2);

        // Random phases over frame sizes and flow-control mixes
        run_phase(640, 480, 0, 0, 120, 1'b0);
        run_phase(1, 1, 60, 0, 100, 1'b0);
        run_phase(4096, 4096, 0, 60, 120, 1'b1);
        run_phase(0, 0, 15, 15, 80, 1'b0);
        run_phase(8191, 8191, 15, 15, 100, 1'b0);
        run_phase($urandom_range(1, 4096), $urandom_range(1, 4096), 0, 0, 100, 1'b0);

        // Backpressure: output held while the sender keeps offering a long line
        set_frame(320, 200);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge i_clk);
        long_hold_req = 1'b1;
        post_start(5, 7, 44, 20, $urandom);
        post_next(40);
        while (!long_hold_done)
            @(posedge i_clk);

        wait_idle();
        if (pixel_errors == 0 && expected_pixels.size() == 0) begin
            $display("PASS bresenham_line_rasterizer");
        end else begin
            $display("FAIL bresenham_line_rasterizer");
        end
        $finish;
    end

endmodule

>>> bresenham_line_rasterizer.f
rtl/blr_pkg.sv
rtl/blr_stepper.sv
rtl/blr_pixel_out.sv
rtl/bresenham_line_rasterizer.sv
rtl/blr_checker.sv
verif/tb.sv
